// ----- rtl/core/cst_pkg.sv -----
// Shared types, constants and per-step tables of the sigmoid / tanh cell chain.
package cst_pkg;

  // Width of the data path and fixed-point constants (Q16)
  localparam int unsigned DataW = 32;
  localparam logic [DataW-1:0] QOne    = 32'd65536;
  localparam logic [DataW-1:0] InvGain = 32'd704813465;

  // Number of steps in each phase
  localparam int NumExp = 4;
  localparam int NumHyp = 17;   // steps 1..15 with steps 4 and 13 taken twice
  localparam int NumLin = 18;

  // Position of each phase along the chain
  localparam int AngleStep = 0;
  localparam int ExpBase   = AngleStep + 1;
  localparam int HypBase   = ExpBase + NumExp;
  localparam int DivStep   = HypBase + NumHyp;
  localparam int LinBase   = DivStep + 1;
  localparam int OutStep   = LinBase + NumLin;
  localparam int NumCells  = OutStep + 1;
  localparam int StepW     = $clog2(NumCells);

  // Function select codes
  localparam logic OpSigmoid = 1'b0;
  localparam logic OpTanh    = 1'b1;

  // Expanded-range angle constants (shifts 16, 8, 4, 2)
  localparam logic [DataW-1:0] ExpAtanh0 = 32'd386121;
  localparam logic [DataW-1:0] ExpAtanh1 = 32'd204353;
  localparam logic [DataW-1:0] ExpAtanh2 = 32'd112524;
  localparam logic [DataW-1:0] ExpAtanh3 = 32'd63763;

  // Hyperbolic angle constants for steps 1..4; later steps are powers of two
  localparam logic [DataW-1:0] HypAtanh1 = 32'd35999;
  localparam logic [DataW-1:0] HypAtanh2 = 32'd16738;
  localparam logic [DataW-1:0] HypAtanh3 = 32'd8235;
  localparam logic [DataW-1:0] HypAtanh4 = 32'd4101;

  typedef enum logic [2:0] {
    KindAngle,
    KindExp,
    KindHyp,
    KindDiv,
    KindLin,
    KindOut
  } step_kind_e;

  // Word handed from cell to cell: (x, y, z) while rotating, (n, d, q) while dividing
  typedef struct packed {
    logic             op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
  } cst_word_t;

  // Role of the cell at a chain position
  function automatic step_kind_e step_kind(logic [StepW-1:0] s);
    step_kind_e k;
    if (s == StepW'(AngleStep)) begin
      k = KindAngle;
    end else if (s < StepW'(HypBase)) begin
      k = KindExp;
    end else if (s < StepW'(DivStep)) begin
      k = KindHyp;
    end else if (s == StepW'(DivStep)) begin
      k = KindDiv;
    end else if (s < StepW'(OutStep)) begin
      k = KindLin;
    end else begin
      k = KindOut;
    end
    return k;
  endfunction

  // Hyperbolic iteration number for a position in the hyperbolic phase
  function automatic int hyp_iter(logic [StepW-1:0] s);
    int j;
    int k;
    j = int'(s) - HypBase;
    if (j < 4) begin
      k = j + 1;
    end else if (j <= 13) begin
      k = j;
    end else begin
      k = j - 1;
    end
    return k;
  endfunction

  // Shift amount of the cell at a chain position
  function automatic logic [4:0] step_shift(logic [StepW-1:0] s);
    int j;
    logic [4:0] sh;
    sh = '0;
    case (step_kind(s))
      KindExp: begin
        j  = int'(s) - ExpBase;
        sh = 5'(16 >> j);
      end
      KindHyp: begin
        sh = 5'(hyp_iter(s));
      end
      KindLin: begin
        j  = int'(s) - LinBase;
        sh = 5'(j);
      end
      default: begin
        sh = '0;
      end
    endcase
    return sh;
  endfunction

  // Angle or quotient-bit constant of the cell at a chain position
  function automatic logic [DataW-1:0] step_const(logic [StepW-1:0] s);
    int j;
    int k;
    logic [DataW-1:0] v;
    v = '0;
    case (step_kind(s))
      KindExp: begin
        j = int'(s) - ExpBase;
        case (j)
          0:       v = ExpAtanh0;
          1:       v = ExpAtanh1;
          2:       v = ExpAtanh2;
          default: v = ExpAtanh3;
        endcase
      end
      KindHyp: begin
        k = hyp_iter(s);
        case (k)
          1:       v = HypAtanh1;
          2:       v = HypAtanh2;
          3:       v = HypAtanh3;
          4:       v = HypAtanh4;
          default: v = DataW'(32'd1 << (16 - k));
        endcase
      end
      KindLin: begin
        j = int'(s) - LinBase;
        v = QOne >> j;
      end
      default: begin
        v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/cordic_sigmoid_tanh.sv -----
// Top level of the sigmoid / tanh unit: a chain of CORDIC step cells.
// Takes one word per cycle while the head cell has room and returns one result per word,
// in order. The chain has one cell per step: angle setup, four expanded-range and
// seventeen hyperbolic rotation steps, a divisor setup, eighteen linear division steps
// and the final sigmoid / tanh correction. Each cell holds one word and passes it on as
// soon as its neighbour has room, so bubbles close up while the output stalls.
module cordic_sigmoid_tanh (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] x_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] y_value_o
);
  import cst_pkg::*;

  logic      valid_w [NumCells+1];
  logic      ready_w [NumCells+1];
  cst_word_t word_w  [NumCells+1];

  // Feed the argument into the head of the chain
  assign valid_w[0] = in_valid_i;
  assign in_ready_o = ready_w[0];
  assign word_w[0]  = '{op: op_i, a: '0, b: '0, c: x_value_i};

  // Build the row of step cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    cst_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (StepW'(g)),
      .valid_i (valid_w[g]),
      .ready_o (ready_w[g]),
      .word_i  (word_w[g]),
      .valid_o (valid_w[g+1]),
      .ready_i (ready_w[g+1]),
      .word_o  (word_w[g+1])
    );
  end

  // Drive the result from the tail of the chain
  assign out_valid_o       = valid_w[NumCells];
  assign ready_w[NumCells] = out_ready_i;
  assign y_value_o         = word_w[NumCells].c;

endmodule

// ----- rtl/core/cst_cell.sv -----
// One register stage of the chain: a single CORDIC step or a setup / finish step.
module cst_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [cst_pkg::StepW-1:0] step_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  cst_pkg::cst_word_t       word_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cst_pkg::cst_word_t       word_o
);
  import cst_pkg::*;

  step_kind_e       kind;
  logic [4:0]       sh;
  logic [DataW-1:0] cst;
  logic [DataW-1:0] asr_a;
  logic [DataW-1:0] asr_b;
  logic [DataW-1:0] dx;
  logic [DataW-1:0] dy;
  cst_word_t        word_d;
  cst_word_t        word_q;
  logic             valid_q;

  // Step role and constants follow from the fixed position
  assign kind  = step_kind(step_i);
  assign sh    = step_shift(step_i);
  assign cst   = step_const(step_i);
  assign asr_a = DataW'($signed(word_i.a) >>> sh);
  assign asr_b = DataW'($signed(word_i.b) >>> sh);

  // Compute the next word for this step
  always_comb begin
    word_d    = word_i;
    dx        = asr_b;
    dy        = asr_a;
    case (kind)
      KindAngle: begin
        word_d.a = InvGain;
        word_d.b = '0;
        word_d.c = (word_i.op == OpSigmoid) ? (DataW'(0) - word_i.c) : (word_i.c << 1);
      end
      KindExp, KindHyp: begin
        if (kind == KindExp) begin
          dx = word_i.b - asr_b;
          dy = word_i.a - asr_a;
        end
        if (word_i.c[DataW-1]) begin
          word_d.a = word_i.a - dx;
          word_d.b = word_i.b - dy;
          word_d.c = word_i.c + cst;
        end else begin
          word_d.a = word_i.a + dx;
          word_d.b = word_i.b + dy;
          word_d.c = word_i.c - cst;
        end
      end
      KindDiv: begin
        word_d.a = QOne;
        word_d.b = word_i.a + word_i.b + QOne;
        word_d.c = '0;
      end
      KindLin: begin
        if (word_i.a[DataW-1]) begin
          word_d.a = word_i.a + asr_b;
          word_d.c = word_i.c - cst;
        end else begin
          word_d.a = word_i.a - asr_b;
          word_d.c = word_i.c + cst;
        end
      end
      KindOut: begin
        if (word_i.op == OpTanh) begin
          word_d.c = QOne - (word_i.c << 1);
        end
      end
      default: begin
        word_d = word_i;
      end
    endcase
  end

  // Take a word when empty or when the neighbour drains this stage
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload until the next word arrives
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sigmoid / tanh unit: scoreboard, word drivers, watchdog.
`timescale 1ns / 100ps

module testbench;
  import cst_pkg::OpSigmoid;
  import cst_pkg::OpTanh;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned WordsPerPhase = 125;
  localparam int unsigned ReportLimit   = 10;

  // Expected results of accepted words, worked out bit for bit
  class activation_board;
    logic [31:0] expected_y[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function logic [31:0] asr(logic [31:0] v, int unsigned sh);
      return $signed(v) >>> sh;
    endfunction

    function logic [31:0] predict_activation(logic op, logic [31:0] arg);
      logic [31:0] x, y, z, dx, dy, ang, n, d, q, qbit;
      int unsigned sh;
      int i, k, r, reps;
      x = 32'd704813465;
      y = '0;
      z = (op == OpSigmoid) ? 32'd0 - arg : arg << 1;
      // Expanded-range steps: shifts 16, 8, 4, 2
      for (i = 0; i < 4; i++) begin
        sh = 16 >> i;
        dx = y - asr(y, sh);
        dy = x - asr(x, sh);
        case (i)
          0:       ang = 32'd386121;
          1:       ang = 32'd204353;
          2:       ang = 32'd112524;
          default: ang = 32'd63763;
        endcase
        if (z[31]) begin
          x = x - dx; y = y - dy; z = z + ang;
        end else begin
          x = x + dx; y = y + dy; z = z - ang;
        end
      end
      // Hyperbolic rotation, steps 4 and 13 taken twice
      for (k = 1; k <= 15; k++) begin
        case (k)
          1:       ang = 32'd35999;
          2:       ang = 32'd16738;
          3:       ang = 32'd8235;
          4:       ang = 32'd4101;
          default: ang = 32'd1 << (16 - k);
        endcase
        reps = (k == 4 || k == 13) ? 2 : 1;
        for (r = 0; r < reps; r++) begin
          dx = asr(y, k);
          dy = asr(x, k);
          if (z[31]) begin
            x = x - dx; y = y - dy; z = z + ang;
          end else begin
            x = x + dx; y = y + dy; z = z - ang;
          end
        end
      end
      // Linear vectoring: 1 / (1 + e^angle)
      d = x + y + 32'd65536;
      n = 32'd65536;
      q = '0;
      for (k = 0; k < 18; k++) begin
        qbit = 32'd65536 >> k;
        if (n[31]) begin
          n = n + asr(d, k); q = q - qbit;
        end else begin
          n = n - asr(d, k); q = q + qbit;
        end
      end
      return (op == OpSigmoid) ? q : 32'd65536 - (q << 1);
    endfunction

    function void note_input(logic op, logic [31:0] arg);
      expected_y.push_back(predict_activation(op, arg));
    endfunction

    function void check_output(logic [31:0] got);
      logic [31:0] want;
      if (expected_y.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected result word: y_value 0x%08h", got);
        end
        return;
      end
      want = expected_y.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("y_value mismatch: expected 0x%08h (%0d), got 0x%08h (%0d)",
                   want, $signed(want), got, $signed(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        op_i;
  logic [31:0] x_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] y_value_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_count;
  activation_board board;

  cordic_sigmoid_tanh dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .x_value_i   (x_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .y_value_o   (y_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic op, input logic [31:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    x_value_i  <= arg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(op, arg);
    @(negedge clk_i);
  endtask

  // Hold off until every expected result has come back
  task automatic drain;
    while (board.expected_y.size() != 0) @(negedge clk_i);
  endtask

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check result words and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_output(y_value_o);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        stall_count <= 0;
      end else if (stall_count >= WatchdogLimit) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    logic [31:0] corner_x [12] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
      32'hFFFF_0000, 32'h0003_8000, 32'hFFFA_0000, 32'h0010_0000,
      32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000
    };
    logic [31:0] arg;
    logic        op;
    int          i, phase, cnt;

    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OpSigmoid;
    x_value_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_count   = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, smallest steps, saturation region, wrap-around and most negative
    for (i = 0; i < 12; i++) begin
      send_word(OpSigmoid, corner_x[i]);
      send_word(OpTanh, corner_x[i]);
    end

    // Random words under three idling patterns
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;  recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86; recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;  recv_idle_pct = 0;
        end
      endcase
      for (cnt = 0; cnt < WordsPerPhase; cnt++) begin
        op = ($urandom_range(1) == 0) ? OpSigmoid : OpTanh;
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: arg = $urandom_range(16 * 65536) - 8 * 65536;
          6, 7:             arg = $urandom();
          8:                arg = ($urandom_range(1) == 0) ? 32'h7FFF_FFFF - $urandom_range(255)
                                                           : 32'h8000_0000 + $urandom_range(255);
          default:          arg = $urandom_range(511) - 256;
        endcase
        send_word(op, arg);
      end
      // After the first phase, pause the sender until the pipeline is empty
      if (phase == 0) begin
        in_valid_i <= 1'b0;
        drain();
      end
    end
    in_valid_i <= 1'b0;

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (board.failures == 0 && board.expected_y.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
